// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock and reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Block form: uses the local clock and reset names.
`define ASSERT_SYNC(label, prop, msg) `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: hw/rtl/bpm_pkg.sv
// ---------------------------------------------------------------------------
// bpm_pkg
// Types, codes and constants shared by the breakpoint pool matcher.
// ---------------------------------------------------------------------------
package bpm_pkg;

   localparam int ADDR_WIDTH  = 32;
   localparam int PNUM_WIDTH  = 32;
   localparam int COUNT_WIDTH = 6;

   localparam int POOL_ENTRIES_DEFAULT = 32;
   localparam int NUMBER_WIDTH_DEFAULT = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef logic [1:0] bpm_cmd_type;
   localparam bpm_cmd_type CMD_ADD    = 2'd0;
   localparam bpm_cmd_type CMD_DELETE = 2'd1;
   localparam bpm_cmd_type CMD_CHECK  = 2'd2;

   typedef logic [1:0] bpm_status_type;
   localparam bpm_status_type STATUS_OK        = 2'd0;
   localparam bpm_status_type STATUS_FULL      = 2'd1;
   localparam bpm_status_type STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      bpm_cmd_type            command;
      logic [ADDR_WIDTH-1:0]  address;
      logic [PNUM_WIDTH-1:0]  point_number;
   } bpm_req_type;

   typedef struct packed {
      bpm_status_type         status;
      logic [PNUM_WIDTH-1:0]  assigned_number;
      logic [COUNT_WIDTH-1:0] removed_count;
      logic                   stop;
   } bpm_rsp_type;

   // Token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic                   active;
      bpm_cmd_type            command;
      logic [ADDR_WIDTH-1:0]  address;
      logic [PNUM_WIDTH-1:0]  point_number;
      logic                   taken;
      logic [COUNT_WIDTH-1:0] removed_count;
      logic                   stop;
   } bpm_probe_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOLD,
      ST_RUN
   } bpm_state_type;

endpackage

// File: hw/rtl/bpm_cell.sv
// ---------------------------------------------------------------------------
// bpm_cell
// One breakpoint slot. Applies the passing probe to its entry and registers
// the updated probe toward the next cell.
// ---------------------------------------------------------------------------
module bpm_cell import bpm_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [NUMBER_WIDTH-1:0] cand_number,
   input  bpm_probe_type           probe_in,
   output bpm_probe_type           probe_out
);

   localparam int CmpWidth = (NUMBER_WIDTH > PNUM_WIDTH) ? NUMBER_WIDTH : PNUM_WIDTH;

   logic                    valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0]   address_ff, address_in;
   logic [NUMBER_WIDTH-1:0] number_ff, number_in;
   bpm_probe_type           probe_out_ff, probe_out_in;
   logic                    num_hit;

   assign num_hit = (probe_in.point_number == '0) ||
                    (CmpWidth'(number_ff) == CmpWidth'(probe_in.point_number));

   always_comb begin
      valid_in     = valid_ff;
      address_in   = address_ff;
      number_in    = number_ff;
      probe_out_in = probe_in;
      if (probe_in.active) begin
         case (probe_in.command)
            CMD_ADD: begin
               // first free slot along the chain takes the entry
               if (!valid_ff && !probe_in.taken) begin
                  valid_in           = 1'b1;
                  address_in         = probe_in.address;
                  number_in          = cand_number;
                  probe_out_in.taken = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (valid_ff && num_hit) begin
                  valid_in = 1'b0;
                  if (probe_in.removed_count != COUNT_MAX) begin
                     probe_out_in.removed_count = probe_in.removed_count + 1'b1;
                  end
               end
            end
            CMD_CHECK: begin
               if (valid_ff && (address_ff == probe_in.address)) begin
                  probe_out_in.stop = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         probe_out_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         probe_out_ff <= probe_out_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      number_ff  <= number_in;
   end

   assign probe_out = probe_out_ff;

endmodule

// File: hw/rtl/breakpoint_pool_matcher.sv
// The request is registered and launched into the chain; the probe visits one
// slot cell per cycle, only one request is in the chain at a time, and the
// response is registered as it leaves the last cell, after which the next
// request is taken. Launch waits while a previous response is still pending.
// Reset: all slots invalid, serial counter zero, no response pending.
// ---------------------------------------------------------------------------
// breakpoint_pool_matcher
// Breakpoint slot chain with add, delete-by-number and program counter check.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module breakpoint_pool_matcher import bpm_pkg::*; #(
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEFAULT,
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bpm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bpm_rsp_type rsp_data
);

   localparam int CmpWidth = (NUMBER_WIDTH > PNUM_WIDTH) ? NUMBER_WIDTH : PNUM_WIDTH;

   bpm_state_type           state_ff, state_in;
   bpm_req_type             req_ff, req_in;
   logic [NUMBER_WIDTH-1:0] counter_ff, counter_in;
   logic [NUMBER_WIDTH-1:0] cand_number;
   logic [CmpWidth-1:0]     cand_wide;
   bpm_rsp_type             rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    launch;
   logic                    done;
   bpm_probe_type           probe [POOL_ENTRIES+1];
   logic [POOL_ENTRIES:0]   active_vec;
   bpm_probe_type           last;

   // Next serial number: wraps from all ones back to 1.
   assign cand_number = (counter_ff == '1) ? NUMBER_WIDTH'(1) : counter_ff + 1'b1;
   assign cand_wide   = CmpWidth'(cand_number);

   // Launch the probe into the first cell.
   always_comb begin
      probe[0]               = '0;
      probe[0].active        = launch;
      probe[0].command       = req_ff.command;
      probe[0].address       = req_ff.address;
      probe[0].point_number  = req_ff.point_number;
   end

   for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
      bpm_cell #(
         .NUMBER_WIDTH(NUMBER_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cand_number(cand_number),
         .probe_in   (probe[i]),
         .probe_out  (probe[i+1])
      );
   end

   for (genvar i = 0; i <= POOL_ENTRIES; i++) begin : g_active
      assign active_vec[i] = probe[i].active;
   end

   assign last = probe[POOL_ENTRIES];
   assign done = last.active;

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic: launch only once the response slot is free or draining,
   // so the result can never land on a pending response.
   always_comb begin
      req_ready = 1'b0;
      launch    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_HOLD: begin
            launch = !rsp_valid_ff || rsp_ready;
         end
         ST_RUN: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      req_in = req_ff;
      if (req_valid && req_ready) begin
         req_in = req_data;
      end
   end

   // Build the response from the probe leaving the last cell.
   always_comb begin
      counter_in   = counter_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         case (last.command)
            CMD_ADD: begin
               if (last.taken) begin
                  counter_in             = cand_number;
                  rsp_in.assigned_number = cand_wide[PNUM_WIDTH-1:0];
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
            CMD_DELETE: begin
               rsp_in.removed_count = last.removed_count;
               if ((last.point_number != '0) && (last.removed_count == '0)) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            CMD_CHECK: begin
               rsp_in.stop = last.stop;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_SYNC(a_single_probe, $countones(active_vec) <= 1, "more than one probe in the chain")
   `ASSERT_SYNC(a_done_in_run, done |-> (state_ff == ST_RUN), "probe left chain outside run")
   `ASSERT_SYNC(a_no_overwrite, done |-> !rsp_valid_ff, "result overwrote a pending response")

endmodule
